// ----- src/bptg_pkg.sv -----
// Shared types, constants and the sine table builder for the beep pattern tone generator.
// No dependencies; every other file of the block imports this package.
package bptg_pkg;

	localparam int unsigned SINE_INDEX_BITS_DEF = 10;
	localparam int unsigned FIFO_DEPTH          = 4;
	localparam int unsigned CFG_DATA_W          = 32;
	localparam int unsigned CFG_INDEX_W         = 3;
	localparam int unsigned SAMPLE_W            = 16;

	// register reset values
	localparam logic [31:0] BOOT_PHASE_STEP_RST = 32'd1342177280;
	localparam logic [31:0] WARN_PHASE_STEP_RST = 32'd1046898278;
	localparam logic [7:0]  BOOT_BURSTS_RST     = 8'd4;
	localparam logic [19:0] BOOT_TONE_LEN_RST   = 20'd1920;
	localparam logic [19:0] BOOT_GAP_LEN_RST    = 20'd1920;
	localparam logic [19:0] WARN_TONE_LEN_RST   = 20'd1600;
	localparam logic [19:0] WARN_GAP_LEN_RST    = 20'd1600;
	localparam logic [23:0] WARN_TOTAL_LEN_RST  = 24'd80000;

	// 0.35 scaling: x*7/20 = ((x*7) >> 2) / 5, the /5 as a reciprocal multiply
	localparam logic [15:0] RECIP_5   = 16'd52429;
	localparam int unsigned RECIP_SHR = 18;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_BOOT_PHASE_STEP = 3'd0,
		REG_WARN_PHASE_STEP = 3'd1,
		REG_BOOT_BURSTS     = 3'd2,
		REG_BOOT_TONE_LEN   = 3'd3,
		REG_BOOT_GAP_LEN    = 3'd4,
		REG_WARN_TONE_LEN   = 3'd5,
		REG_WARN_GAP_LEN    = 3'd6,
		REG_WARN_TOTAL_LEN  = 3'd7
	} reg_idx_t;

	// per-tick control word from the sequencer to the sample path
	typedef struct packed {
		logic sounding;
		logic tone;
	} tick_ctl_t;

	// Quarter-wave sine, Q30 Taylor series in Horner form, rounded to 15 bits.
	// qb is log2 of the quarter length. Elaboration use only.
	function automatic logic [14:0] quarter_sine(input int unsigned q, input int unsigned qb);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] v;
		logic [63:0] one;
		one = 64'd1 << 30;
		x   = (64'd1686629713 * 64'(q)) >> qb;
		x2  = (x * x) >> 30;
		t   = one;
		t   = one - ((x2 * t) >> 30) / 110;
		t   = one - ((x2 * t) >> 30) / 72;
		t   = one - ((x2 * t) >> 30) / 42;
		t   = one - ((x2 * t) >> 30) / 20;
		t   = one - ((x2 * t) >> 30) / 6;
		s   = (x * t) >> 30;
		v   = (s * 64'd32767 + (64'd1 << 29)) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[14:0];
	endfunction

endpackage

// ----- src/bptg_channels.sv -----
// Handshake channel interfaces: sample tick requests in, PCM words out.
// Depends on bptg_pkg for the sample width.
interface bptg_tick_if;
	logic valid;
	logic ready;
	logic boot_request;
	logic warn_level;

	modport source (output valid, output boot_request, output warn_level, input ready);
	modport sink   (input valid, input boot_request, input warn_level, output ready);
endinterface

interface bptg_pcm_if import bptg_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       sounding;

	modport source (output valid, output sample, output sounding, input ready);
	modport sink   (input valid, input sample, input sounding, output ready);
endinterface

// ----- src/bptg_front.sv -----
// Front end: configuration registers and the chime/train sequencer, one tick per word.
// Depends on bptg_pkg; emits a control word and a sine table index per accepted tick.
module bptg_front import bptg_pkg::*; #(
	parameter int unsigned SINE_INDEX_BITS = SINE_INDEX_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       accept,
	input  logic                       boot_request,
	input  logic                       warn_level,
	output tick_ctl_t                  ctl,
	output logic [SINE_INDEX_BITS-1:0] idx
);

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_BOOT = 2'd1,
		MODE_WARN = 2'd2
	} mode_t;

	logic [31:0] boot_step_q, warn_step_q;
	logic [7:0]  boot_count_q;
	logic [19:0] boot_tone_q, boot_gap_q, warn_tone_q, warn_gap_q;
	logic [23:0] warn_total_q;

	mode_t       mode_q, mode_n;
	logic        gap_q, gap_n;
	logic [19:0] seg_q, seg_n;
	logic [7:0]  bursts_q, bursts_n;
	logic [23:0] elapsed_q, elapsed_n;
	logic [31:0] phase_q, phase_n;
	logic        last_warn_q;
	logic        rise;
	logic        boundary;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_step_q  <= BOOT_PHASE_STEP_RST;
			warn_step_q  <= WARN_PHASE_STEP_RST;
			boot_count_q <= BOOT_BURSTS_RST;
			boot_tone_q  <= BOOT_TONE_LEN_RST;
			boot_gap_q   <= BOOT_GAP_LEN_RST;
			warn_tone_q  <= WARN_TONE_LEN_RST;
			warn_gap_q   <= WARN_GAP_LEN_RST;
			warn_total_q <= WARN_TOTAL_LEN_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_BOOT_PHASE_STEP: boot_step_q  <= cfg_data;
				REG_WARN_PHASE_STEP: warn_step_q  <= cfg_data;
				REG_BOOT_BURSTS:     boot_count_q <= cfg_data[7:0];
				REG_BOOT_TONE_LEN:   boot_tone_q  <= cfg_data[19:0];
				REG_BOOT_GAP_LEN:    boot_gap_q   <= cfg_data[19:0];
				REG_WARN_TONE_LEN:   warn_tone_q  <= cfg_data[19:0];
				REG_WARN_GAP_LEN:    warn_gap_q   <= cfg_data[19:0];
				REG_WARN_TOTAL_LEN:  warn_total_q <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	assign rise = warn_level & ~last_warn_q;

	always_comb begin
		mode_n    = mode_q;
		gap_n     = gap_q;
		seg_n     = seg_q;
		bursts_n  = bursts_q;
		elapsed_n = elapsed_q;
		phase_n   = phase_q;
		boundary  = 1'b0;
		ctl       = '0;
		idx       = '0;

		if (mode_q == MODE_IDLE) begin
			if (boot_request && boot_count_q != '0 && boot_tone_q != '0) begin
				mode_n   = MODE_BOOT;
				bursts_n = '0;
				gap_n    = 1'b0;
				seg_n    = '0;
				phase_n  = '0;
			end else if (rise && warn_tone_q != '0 && warn_total_q != '0) begin
				mode_n    = MODE_WARN;
				elapsed_n = '0;
				gap_n     = 1'b0;
				seg_n     = '0;
				phase_n   = '0;
			end
		end

		// warning cleared: stop now unless a gap is already under way
		if (mode_n == MODE_WARN && !warn_level && (!gap_n || seg_n == '0)) begin
			mode_n = MODE_IDLE;
		end

		unique case (mode_n)
			MODE_BOOT: begin
				ctl.sounding = 1'b1;
				if (!gap_n) begin
					ctl.tone = 1'b1;
					idx      = phase_n[31 -: SINE_INDEX_BITS];
					phase_n  = phase_n + boot_step_q;
					seg_n    = seg_n + 20'd1;
					if (seg_n >= boot_tone_q) begin
						if (bursts_n != 8'hFF) begin
							bursts_n = bursts_n + 8'd1;
						end
						if (bursts_n >= boot_count_q) begin
							mode_n = MODE_IDLE;
						end else if (boot_gap_q != '0) begin
							gap_n = 1'b1;
							seg_n = '0;
						end else begin
							seg_n   = '0;
							phase_n = '0;
						end
					end
				end else begin
					seg_n = seg_n + 20'd1;
					if (seg_n >= boot_gap_q) begin
						gap_n   = 1'b0;
						seg_n   = '0;
						phase_n = '0;
					end
				end
			end
			MODE_WARN: begin
				ctl.sounding = 1'b1;
				if (elapsed_n != '1) begin
					elapsed_n = elapsed_n + 24'd1;
				end
				if (!gap_n) begin
					ctl.tone = 1'b1;
					idx      = phase_n[31 -: SINE_INDEX_BITS];
					phase_n  = phase_n + warn_step_q;
					seg_n    = seg_n + 20'd1;
					if (seg_n >= warn_tone_q) begin
						if (warn_gap_q != '0) begin
							gap_n = 1'b1;
							seg_n = '0;
						end else begin
							boundary = 1'b1;
						end
					end
				end else begin
					seg_n = seg_n + 20'd1;
					if (seg_n >= warn_gap_q) begin
						boundary = 1'b1;
					end
				end
				if (boundary) begin
					if (elapsed_n >= warn_total_q) begin
						mode_n = MODE_IDLE;
					end else begin
						gap_n   = 1'b0;
						seg_n   = '0;
						phase_n = '0;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			gap_q       <= 1'b0;
			seg_q       <= '0;
			bursts_q    <= '0;
			elapsed_q   <= '0;
			phase_q     <= '0;
			last_warn_q <= 1'b0;
		end else if (accept) begin
			mode_q      <= mode_n;
			gap_q       <= gap_n;
			seg_q       <= seg_n;
			bursts_q    <= bursts_n;
			elapsed_q   <= elapsed_n;
			phase_q     <= phase_n;
			last_warn_q <= warn_level;
		end
	end

endmodule

// ----- src/bptg_fifo.sv -----
// Short first-in first-out queue between the sequencer and the sample path.
// Depends on bptg_pkg for its depth.
module bptg_fifo import bptg_pkg::*; #(
	parameter int unsigned WIDTH = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int unsigned AW = $clog2(FIFO_DEPTH);

	logic [WIDTH-1:0] mem_q [FIFO_DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [AW:0]      count_q;

	assign full  = (count_q == (AW+1)'(FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (AW+1)'(FIFO_DEPTH))
		else $error("queue count beyond depth");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty queue");

endmodule

// ----- src/bptg_back.sv -----
// Back end: quarter-wave sine table, 0.35 scaler and the output register.
// Depends on bptg_pkg for the table builder and scaling constants.
module bptg_back import bptg_pkg::*; #(
	parameter int unsigned SINE_INDEX_BITS = SINE_INDEX_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       empty,
	input  tick_ctl_t                  head_ctl,
	input  logic [SINE_INDEX_BITS-1:0] head_idx,
	output logic                       pop,
	output logic                       pcm_valid,
	input  logic                       pcm_ready,
	output logic signed [SAMPLE_W-1:0] pcm_sample,
	output logic                       pcm_sounding
);

	localparam int unsigned QB      = SINE_INDEX_BITS - 2;
	localparam int unsigned QUARTER = 1 << QB;
	localparam logic [SINE_INDEX_BITS-2:0] QTR = {1'b1, {QB{1'b0}}};

	logic [14:0] rom [QUARTER+1];

	for (genvar i = 0; i <= QUARTER; i++) begin : g_rom
		localparam logic [14:0] VAL = quarter_sine(i, QB);
		assign rom[i] = VAL;
	end

	logic                       adv;
	logic [1:0]                 quad;
	logic [SINE_INDEX_BITS-2:0] q;

	logic        v_s1, neg_s1, snd_s1;
	logic [14:0] mag_s1;
	logic [17:0] mag7;
	logic        v_s2, neg_s2, snd_s2;
	logic [31:0] prod_s2;
	logic [13:0] mag_o;
	logic        out_v_q;

	// whole path moves together; a stalled output word holds everything behind it
	assign adv  = !out_v_q || pcm_ready;
	assign pop  = adv && !empty;
	assign quad = head_idx[SINE_INDEX_BITS-1 -: 2];
	assign q    = quad[0] ? QTR - {1'b0, head_idx[QB-1:0]} : {1'b0, head_idx[QB-1:0]};

	assign mag7  = {mag_s1, 3'b000} - {3'b000, mag_s1};
	assign mag_o = prod_s2[RECIP_SHR +: 14];

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1  <= head_ctl.tone ? rom[q] : '0;
			neg_s1  <= quad[1];
			snd_s1  <= head_ctl.sounding;
			prod_s2 <= 32'(mag7[17:2]) * 32'(RECIP_5);
			neg_s2  <= neg_s1;
			snd_s2  <= snd_s1;
			if (neg_s2) begin
				pcm_sample <= -$signed({2'b00, mag_o});
			end else begin
				pcm_sample <= $signed({2'b00, mag_o});
			end
			pcm_sounding <= snd_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= pop;
			v_s2    <= v_s1;
			out_v_q <= v_s2;
		end
	end

	assign pcm_valid = out_v_q;

	a_silent_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pcm_valid && !pcm_sounding |-> pcm_sample == '0)
		else $error("non-zero sample outside a chime or train");

	a_amp_range: assert property (@(posedge clk) disable iff (!arst_n)
		pcm_valid |-> (pcm_sample <= 16'sd11468) && (pcm_sample >= -16'sd11468))
		else $error("scaled sample out of range");

endmodule

// ----- src/beep_pattern_tone_generator.sv -----
// Top level of the beep pattern tone generator: sequencer, queue and sample path.
// Depends on bptg_pkg, bptg_channels, bptg_front, bptg_fifo and bptg_back.
//
// One tick word in gives one PCM word out, at one word per clock sustained while the pcm side is ready.
// A tick word carries boot_request and warn_level; the sequencer in the front
// end updates its counters and the 32-bit phase accumulator in the cycle the
// word is taken and drops a control word plus a sine table index into a
// four-word queue. The back end reads the quarter-wave sine table, scales by
// 0.35 (x*7/20, truncated toward zero) and registers the result; a sample
// leaves via the s1, s2 and output registers once the output side is ready.
// tick.ready falls only when the queue is full: once the pcm side stalls the
// queue fills up to four words, then tick.ready drops, and it rises again the
// cycle after a word leaves the queue. A boot request starts the configured
// number of bursts with gaps between them; a rising warn_level starts a
// warning train that ends at a burst boundary once warn_total_len samples have
// elapsed, or when warn_level clears (at once during a tone, at the end of a
// gap that has begun). Triggers while busy are dropped, and a boot request
// wins over a warning edge on the same tick. Idle ticks give sample 0 with
// sounding 0. Registers are written through cfg_we/cfg_index/cfg_data with
// the index order: boot phase step, warn phase step, boot burst count, boot
// tone length, boot gap length, warn tone length, warn gap length, warn total
// length; write them only while no ticks are in flight.
module beep_pattern_tone_generator import bptg_pkg::*; #(
	parameter int unsigned SINE_INDEX_BITS = SINE_INDEX_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	bptg_tick_if.sink              tick,
	bptg_pcm_if.source             pcm
);

	localparam int unsigned QW = $bits(tick_ctl_t) + SINE_INDEX_BITS;

	tick_ctl_t                  push_ctl, head_ctl;
	logic [SINE_INDEX_BITS-1:0] push_idx, head_idx;
	logic                       full, empty, pop, accept;

	// a word is taken whenever the queue has room
	assign tick.ready = !full;
	assign accept     = tick.valid && !full;

	bptg_front #(
		.SINE_INDEX_BITS (SINE_INDEX_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.accept       (accept),
		.boot_request (tick.boot_request),
		.warn_level   (tick.warn_level),
		.ctl          (push_ctl),
		.idx          (push_idx)
	);

	bptg_fifo #(
		.WIDTH (QW)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  ({push_ctl, push_idx}),
		.pop    (pop),
		.rdata  ({head_ctl, head_idx}),
		.full   (full),
		.empty  (empty)
	);

	bptg_back #(
		.SINE_INDEX_BITS (SINE_INDEX_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.head_ctl     (head_ctl),
		.head_idx     (head_idx),
		.pop          (pop),
		.pcm_valid    (pcm.valid),
		.pcm_ready    (pcm.ready),
		.pcm_sample   (pcm.sample),
		.pcm_sounding (pcm.sounding)
	);

endmodule

// ----- verif/bptg_sample_checker.sv -----
// Scoreboard for the beep pattern tone generator: predicts one PCM word per tick word
// from the register writes and tick words it sees, then compares the words that leave.
// Depends on bptg_pkg and the channel interfaces of bptg_channels.
module bptg_sample_checker import bptg_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	bptg_tick_if                   tick,
	bptg_pcm_if                    pcm,
	output int unsigned            fail_count,
	output int unsigned            pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned IDX_BITS = SINE_INDEX_BITS_DEF;
	localparam int unsigned LUT_SIZE = 1 << IDX_BITS;
	localparam int unsigned QTR      = LUT_SIZE / 4;
	localparam logic [63:0] Q30      = 64'd1 << 30;
	localparam int unsigned SHOWN    = 10;

	typedef enum logic [1:0] {
		PLAY_IDLE,
		PLAY_BOOT,
		PLAY_WARN
	} play_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       sounding;
	} pcm_word_t;

	// register copies
	logic [31:0] boot_step;
	logic [31:0] warn_step;
	logic [7:0]  boot_count;
	logic [19:0] boot_tone;
	logic [19:0] boot_gap;
	logic [19:0] warn_tone;
	logic [19:0] warn_gap;
	logic [23:0] warn_total;

	// sequencer state
	play_t       mode;
	logic        in_gap;
	logic [31:0] seg_cnt;
	logic [7:0]  bursts;
	logic [23:0] elapsed;
	logic [31:0] phase;
	logic        warn_prev;

	logic signed [15:0] sine_lut [LUT_SIZE];
	pcm_word_t          sample_q [$];
	pcm_word_t          want;
	pcm_word_t          got;

	// table build scratch
	logic [63:0] x;
	logic [63:0] x2;
	logic [63:0] t;
	logic [63:0] s;
	logic [63:0] v;
	int unsigned q;
	int unsigned quad;
	int unsigned horner_div [5];

	// full-wave table folded from a quarter wave of a Q30 Taylor series, rounded to 15 bits
	initial begin
		horner_div = '{110, 72, 42, 20, 6};
		for (int i = 0; i < LUT_SIZE; i++) begin
			quad = i / QTR;
			q    = ((quad & 1) != 0) ? QTR - (i % QTR) : i % QTR;
			x    = (64'd1686629713 * 64'(q)) / QTR;
			x2   = (x * x) >> 30;
			t    = Q30;
			for (int k = 0; k < 5; k++) begin
				t = Q30 - ((x2 * t) >> 30) / horner_div[k];
			end
			s = (x * t) >> 30;
			v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
			if (v > 64'd32767) begin
				v = 64'd32767;
			end
			sine_lut[i] = ((quad & 2) != 0) ? -$signed(v[15:0]) : $signed(v[15:0]);
		end
	end

	function automatic void open_burst();
		in_gap  = 1'b0;
		seg_cnt = '0;
		phase   = '0;
	endfunction

	// table read at the current phase, then advance; x*7/20 truncates toward zero
	function automatic logic signed [15:0] tone_value(logic [31:0] step);
		int raw;
		raw   = sine_lut[phase[31 -: IDX_BITS]];
		phase = phase + step;
		return 16'((raw * 7) / 20);
	endfunction

	function automatic pcm_word_t predict_word(logic boot, logic warn);
		logic      rise;
		logic      boundary;
		pcm_word_t w;
		rise      = warn & ~warn_prev;
		warn_prev = warn;
		boundary  = 1'b0;
		w         = '0;

		if (mode == PLAY_IDLE) begin
			if (boot && boot_count != 0 && boot_tone != 0) begin
				mode   = PLAY_BOOT;
				bursts = '0;
				open_burst();
			end else if (rise && warn_tone != 0 && warn_total != 0) begin
				mode    = PLAY_WARN;
				elapsed = '0;
				open_burst();
			end
		end

		// warning cleared: stop at once unless a gap is already under way
		if (mode == PLAY_WARN && !warn && (!in_gap || seg_cnt == 0)) begin
			mode = PLAY_IDLE;
		end
		if (mode == PLAY_IDLE) begin
			return w;
		end

		w.sounding = 1'b1;
		if (mode == PLAY_BOOT) begin
			seg_cnt = seg_cnt + 1;
			if (!in_gap) begin
				w.sample = tone_value(boot_step);
				if (seg_cnt >= boot_tone) begin
					if (bursts != 8'hFF) begin
						bursts = bursts + 1;
					end
					if (bursts >= boot_count) begin
						mode = PLAY_IDLE;
					end else if (boot_gap != 0) begin
						in_gap  = 1'b1;
						seg_cnt = '0;
					end else begin
						open_burst();
					end
				end
			end else if (seg_cnt >= boot_gap) begin
				open_burst();
			end
		end else begin
			if (elapsed != 24'hFFFFFF) begin
				elapsed = elapsed + 1;
			end
			seg_cnt = seg_cnt + 1;
			if (!in_gap) begin
				w.sample = tone_value(warn_step);
				if (seg_cnt >= warn_tone) begin
					if (warn_gap != 0) begin
						in_gap  = 1'b1;
						seg_cnt = '0;
					end else begin
						boundary = 1'b1;
					end
				end
			end else if (seg_cnt >= warn_gap) begin
				boundary = 1'b1;
			end
			if (boundary) begin
				if (elapsed >= warn_total) begin
					mode = PLAY_IDLE;
				end else begin
					open_burst();
				end
			end
		end
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_step  = BOOT_PHASE_STEP_RST;
			warn_step  = WARN_PHASE_STEP_RST;
			boot_count = BOOT_BURSTS_RST;
			boot_tone  = BOOT_TONE_LEN_RST;
			boot_gap   = BOOT_GAP_LEN_RST;
			warn_tone  = WARN_TONE_LEN_RST;
			warn_gap   = WARN_GAP_LEN_RST;
			warn_total = WARN_TOTAL_LEN_RST;
			mode       = PLAY_IDLE;
			in_gap     = 1'b0;
			seg_cnt    = '0;
			bursts     = '0;
			elapsed    = '0;
			phase      = '0;
			warn_prev  = 1'b0;
			fail_count = 0;
			pending    = 0;
			sample_q.delete();
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_BOOT_PHASE_STEP: boot_step  = cfg_data;
					REG_WARN_PHASE_STEP: warn_step  = cfg_data;
					REG_BOOT_BURSTS:     boot_count = cfg_data[7:0];
					REG_BOOT_TONE_LEN:   boot_tone  = cfg_data[19:0];
					REG_BOOT_GAP_LEN:    boot_gap   = cfg_data[19:0];
					REG_WARN_TONE_LEN:   warn_tone  = cfg_data[19:0];
					REG_WARN_GAP_LEN:    warn_gap   = cfg_data[19:0];
					REG_WARN_TOTAL_LEN:  warn_total = cfg_data[23:0];
				endcase
			end
			if (tick.valid && tick.ready) begin
				sample_q.push_back(predict_word(tick.boot_request, tick.warn_level));
			end
			if (pcm.valid && pcm.ready) begin
				got.sample   = pcm.sample;
				got.sounding = pcm.sounding;
				if (sample_q.size() == 0) begin
					if (fail_count < SHOWN) begin
						$display("unexpected pcm word: sample %0d sounding %0b",
							$signed(got.sample), got.sounding);
					end
					fail_count++;
				end else begin
					want = sample_q.pop_front();
					if (want.sample !== got.sample || want.sounding !== got.sounding) begin
						if (fail_count < SHOWN) begin
							$display("pcm mismatch: sample exp %0d got %0d, sounding exp %0b got %0b",
								$signed(want.sample), $signed(got.sample),
								want.sounding, got.sounding);
						end
						fail_count++;
					end
				end
			end
			pending = sample_q.size();
		end
	end

endmodule

// ----- verif/beep_pattern_tone_generator_tb.sv -----
// Testbench top for the beep pattern tone generator: clock, reset, register set-up,
// tick stimulus and pcm back-pressure; bptg_sample_checker does the prediction.
// Depends on bptg_pkg, bptg_channels, the block itself and verif/bptg_sample_checker.
module beep_pattern_tone_generator_tb import bptg_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned REG_COUNT    = 8;
	localparam int unsigned PHASES       = 6;
	localparam int unsigned PHASE_WORDS  = 190;
	localparam int unsigned DRAIN_CYCLES = 8;   // output side lags behind the back end registers
	localparam int unsigned TIMEOUT_NS   = 2000000;

	// setting selectors for program_setting
	localparam int unsigned SET_SMALL_A  = 0;
	localparam int unsigned SET_EXTREME  = 1;
	localparam int unsigned SET_EDGES    = 2;
	localparam int unsigned SET_SMALL_B  = 3;
	localparam int unsigned SET_LONG     = 4;
	localparam int unsigned SET_SMALL_C  = 5;
	localparam int unsigned SET_DIRECTED = 6;

	// directed tick words: {boot_request, warn_level}
	localparam logic [1:0] T_IDLE = 2'b00;
	localparam logic [1:0] T_BOOT = 2'b10;
	localparam logic [1:0] T_WARN = 2'b01;
	localparam logic [1:0] T_BOTH = 2'b11;

	// With boot: 2 bursts of 3, gap 2; warn: tone 3, gap 2, total 12.
	localparam logic [0:25] [1:0] DIRECTED = {
		T_IDLE,                                  // nothing playing
		T_BOOT, T_BOTH, T_IDLE,                  // chime starts, busy triggers dropped
		T_BOOT, T_IDLE,                          // busy boot request inside the gap
		T_IDLE, T_IDLE, T_IDLE, T_IDLE,          // second burst, chime ends, idle
		T_WARN, T_WARN, T_IDLE,                  // train, cleared during a tone
		T_WARN, T_WARN, T_WARN, T_IDLE,          // cleared just before the gap's first sample
		T_WARN, T_WARN, T_WARN, T_WARN,          // into a gap that has begun
		T_IDLE, T_IDLE,                          // gap plays out, next tone tick stops it
		T_BOTH, T_WARN, T_IDLE                   // boot wins, the warning edge is lost
	};

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	bptg_tick_if tick_ch ();
	bptg_pcm_if  pcm_ch ();

	int unsigned fail_count;
	int unsigned pending;

	int unsigned src_idle_pct;
	int unsigned sink_idle_pct;
	int unsigned toggle_span;
	int unsigned boot_span;
	int unsigned pcm_taken;
	int unsigned hold_left;
	logic        boot_bit;
	logic        warn_bit;
	logic        warn_lvl;
	logic [CFG_DATA_W-1:0] reg_val [REG_COUNT];

	beep_pattern_tone_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tick      (tick_ch),
		.pcm       (pcm_ch)
	);

	bptg_sample_checker sample_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.tick       (tick_ch),
		.pcm        (pcm_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #2 clk = ~clk;

	// hard stop in case the block wedges
	initial begin
		#(TIMEOUT_NS * 1ns);
		$display("beep_pattern_tone_generator_tb: done, errors");
		$finish;
	end

	// Receiver: random ready at sink_idle_pct; after its 150th word (and every 500
	// thereafter) it holds off so the queue fills and tick.ready drops.
	initial begin
		pcm_ch.ready <= 1'b0;
		pcm_taken = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (pcm_ch.valid && pcm_ch.ready) begin
				pcm_taken++;
				if (pcm_taken % 500 == 150) begin
					hold_left = 400;
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				pcm_ch.ready <= 1'b0;
			end else begin
				pcm_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	// high data bits beyond a register's width carry junk; the block must ignore them
	function automatic logic [31:0] with_junk(logic [31:0] val, int unsigned width);
		logic [31:0] junk;
		junk = $urandom();
		return (width >= 32) ? val : (val | (junk << width));
	endfunction

	// Offer one tick word; random idle cycles first, each with a junk payload.
	task automatic offer_tick(input logic boot, input logic warn);
		while ($urandom_range(99) < src_idle_pct) begin
			tick_ch.valid        <= 1'b0;
			tick_ch.boot_request <= 1'($urandom_range(1));
			tick_ch.warn_level   <= 1'($urandom_range(1));
			@(posedge clk);
		end
		tick_ch.valid        <= 1'b1;
		tick_ch.boot_request <= boot;
		tick_ch.warn_level   <= warn;
		do @(posedge clk); while (!tick_ch.ready);
	endtask

	// Stop offering and wait until every predicted word has come back. The
	// count is read on the falling edge, clear of the rising-edge updates.
	task automatic drain_pcm();
		tick_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Build one register setting and write all eight registers back to back.
	task automatic program_setting(input int unsigned sel);
		case (sel)
			SET_DIRECTED: begin
				reg_val[REG_BOOT_PHASE_STEP] = 32'h0400_0000;
				reg_val[REG_WARN_PHASE_STEP] = 32'h1000_0000;
				reg_val[REG_BOOT_BURSTS]     = 2;
				reg_val[REG_BOOT_TONE_LEN]   = 3;
				reg_val[REG_BOOT_GAP_LEN]    = 2;
				reg_val[REG_WARN_TONE_LEN]   = 3;
				reg_val[REG_WARN_GAP_LEN]    = 2;
				reg_val[REG_WARN_TOTAL_LEN]  = 12;
			end
			SET_EXTREME: begin
				// 255 single-sample bursts with no gaps; train disabled by zero tone
				reg_val[REG_BOOT_PHASE_STEP] = 32'h0000_0000;
				reg_val[REG_WARN_PHASE_STEP] = 32'hFFFF_FFFF;
				reg_val[REG_BOOT_BURSTS]     = 255;
				reg_val[REG_BOOT_TONE_LEN]   = 1;
				reg_val[REG_BOOT_GAP_LEN]    = 0;
				reg_val[REG_WARN_TONE_LEN]   = 0;
				reg_val[REG_WARN_GAP_LEN]    = 20'hFFFFF;
				reg_val[REG_WARN_TOTAL_LEN]  = 24'hFFFFFF;
			end
			SET_EDGES: begin
				// chime disabled by zero count; shortest train that has a gap
				reg_val[REG_BOOT_PHASE_STEP] = 32'hFFFF_FFFF;
				reg_val[REG_WARN_PHASE_STEP] = $urandom();
				reg_val[REG_BOOT_BURSTS]     = 0;
				reg_val[REG_BOOT_TONE_LEN]   = 20'hFFFFF;
				reg_val[REG_BOOT_GAP_LEN]    = 20'hFFFFF;
				reg_val[REG_WARN_TONE_LEN]   = 1;
				reg_val[REG_WARN_GAP_LEN]    = 1;
				reg_val[REG_WARN_TOTAL_LEN]  = 1;
			end
			SET_LONG: begin
				// chime disabled by zero tone length; one long tone per warning
				reg_val[REG_BOOT_PHASE_STEP] = $urandom();
				reg_val[REG_WARN_PHASE_STEP] = $urandom_range(32'h0400_0000);
				reg_val[REG_BOOT_BURSTS]     = $urandom_range(255, 1);
				reg_val[REG_BOOT_TONE_LEN]   = 0;
				reg_val[REG_BOOT_GAP_LEN]    = 0;
				reg_val[REG_WARN_TONE_LEN]   = 20'hFFFFF;
				reg_val[REG_WARN_GAP_LEN]    = 3;
				reg_val[REG_WARN_TOTAL_LEN]  = 24'hFFFFFF;
			end
			default: begin
				// short random bursts and trains, junk above each register's width
				reg_val[REG_BOOT_PHASE_STEP] = $urandom();
				reg_val[REG_WARN_PHASE_STEP] = $urandom();
				reg_val[REG_BOOT_BURSTS]     = with_junk($urandom_range(4, 1), 8);
				reg_val[REG_BOOT_TONE_LEN]   = with_junk($urandom_range(8, 1), 20);
				reg_val[REG_BOOT_GAP_LEN]    = with_junk($urandom_range(5, 0), 20);
				reg_val[REG_WARN_TONE_LEN]   = with_junk($urandom_range(8, 1), 20);
				reg_val[REG_WARN_GAP_LEN]    = with_junk($urandom_range(5, 0), 20);
				reg_val[REG_WARN_TOTAL_LEN]  = with_junk($urandom_range(60, 1), 24);
			end
		endcase
		for (int r = 0; r < REG_COUNT; r++) begin
			cfg_we    <= 1'b1;
			cfg_index <= reg_idx_t'(r);
			cfg_data  <= reg_val[r];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n               <= 1'b0;
		cfg_we               <= 1'b0;
		cfg_index            <= '0;
		cfg_data             <= '0;
		tick_ch.valid        <= 1'b0;
		tick_ch.boot_request <= 1'b0;
		tick_ch.warn_level   <= 1'b0;
		src_idle_pct  = 23;
		sink_idle_pct = 86;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words: each trigger path, the chime end and the warning-clear stop rules
		program_setting(SET_DIRECTED);
		for (int n = 0; n < $size(DIRECTED); n++) begin
			offer_tick(DIRECTED[n][1], DIRECTED[n][0]);
		end
		drain_pcm();

		// random phases; idling pattern changes every two phases
		for (int p = 0; p < PHASES; p++) begin
			case (p / 2)
				0: begin
					src_idle_pct  = 23;
					sink_idle_pct = 86;
				end
				1: begin
					src_idle_pct  = 86;
					sink_idle_pct = 23;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
			endcase
			program_setting(p);
			toggle_span = (p == SET_LONG) ? 40 : 6;
			boot_span   = (p == SET_EXTREME) ? 60 : 20;
			warn_lvl    = 1'b0;
			for (int n = 0; n < PHASE_WORDS; n++) begin
				// mostly held warning levels with occasional boot requests,
				// one word in ten fully random
				if ($urandom_range(9) == 0) begin
					boot_bit = 1'($urandom_range(1));
					warn_bit = 1'($urandom_range(1));
				end else begin
					if ($urandom_range(toggle_span) == 0) begin
						warn_lvl = ~warn_lvl;
					end
					boot_bit = ($urandom_range(boot_span) == 0);
					warn_bit = warn_lvl;
				end
				offer_tick(boot_bit, warn_bit);
			end
			// sender waits for every outstanding word before the next setting
			drain_pcm();
		end

		if (fail_count == 0 && pending == 0) begin
			$display("beep_pattern_tone_generator_tb: done, clean");
		end else begin
			$display("beep_pattern_tone_generator_tb: done, errors");
		end
		$finish;
	end

endmodule
